// ===== hw/rtl/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared widths and the tile class codes of the triangle tile coverage unit.
// ----------------------------------------------------------------------------
package ttc_pkg;

    // Vertex and tile origin coordinates
    localparam int COORD_W = 12;
    // Coverage mask port width
    localparam int MASK_W  = 16;
    // Doubled triangle area width
    localparam int AREA_W  = 26;
    // Internal width of edge function values, headroom over the 27-bit worst case
    localparam int EDGE_W  = 30;

    typedef enum logic [1:0] {
        TILE_OUTSIDE = 2'd0,
        TILE_INSIDE  = 2'd1,
        TILE_CROSSED = 2'd2
    } tile_class_t;

endpackage

// ===== hw/rtl/triangle_tile_coverage_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_tile_coverage_unit
// Half-space test of one triangle against one square pixel tile.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries three signed vertices and the
// unsigned top-left pixel of a TILE_DIM x TILE_DIM tile. Output channel
// (out_valid / out_ready) returns one item per input: the tile class
// (outside, fully inside, crossed), a coverage mask with bit x + y*TILE_DIM
// set for each covered pixel (bits at 16 and above are dropped), and the
// signed doubled area of the triangle.
// The item is captured in an input register when it is accepted; the edge
// setup, corner tests and per-pixel tests run in one combinational pass and
// the result lands in the output register, which raises out_valid, as soon
// as that register is empty or its item is being taken.
// Throughput is one item per cycle unless out_ready is low; the two registers
// form a two-deep pipeline, so a new item is taken while a result waits.
// When the receiver stalls, the output register holds its item and the
// input register fills; in_ready drops only when both are full.
// Reset empties both stages; the data registers themselves are not reset.
// ----------------------------------------------------------------------------
module triangle_tile_coverage_unit #(
    parameter int TILE_DIM = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert0_x,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert0_y,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert1_x,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert1_y,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert2_x,
    input  logic signed [ttc_pkg::COORD_W-1:0]  vert2_y,
    input  logic        [ttc_pkg::COORD_W-1:0]  tile_origin_x,
    input  logic        [ttc_pkg::COORD_W-1:0]  tile_origin_y,

    output logic                                out_valid,
    input  logic                                out_ready,
    output ttc_pkg::tile_class_t                tile_class,
    output logic        [ttc_pkg::MASK_W-1:0]   coverage_mask,
    output logic signed [ttc_pkg::AREA_W-1:0]   doubled_area
);

    localparam int W     = ttc_pkg::EDGE_W;
    localparam int MW    = ttc_pkg::MASK_W;
    localparam int SPAN  = TILE_DIM - 1;
    localparam int NPIX  = TILE_DIM * TILE_DIM;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;
    logic s1_advance;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic signed [ttc_pkg::COORD_W-1:0] vx_reg [3];
    logic signed [ttc_pkg::COORD_W-1:0] vy_reg [3];
    logic        [ttc_pkg::COORD_W-1:0] ox_reg;
    logic        [ttc_pkg::COORD_W-1:0] oy_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            vx_reg[0] <= vert0_x;
            vy_reg[0] <= vert0_y;
            vx_reg[1] <= vert1_x;
            vy_reg[1] <= vert1_y;
            vx_reg[2] <= vert2_x;
            vy_reg[2] <= vert2_y;
            ox_reg    <= tile_origin_x;
            oy_reg    <= tile_origin_y;
        end
    end

    // ------------------------------------------------------------------
    // Edge setup and corner tests
    // ------------------------------------------------------------------
    logic signed [W-1:0] vxw [3];
    logic signed [W-1:0] vyw [3];
    logic signed [W-1:0] oxw;
    logic signed [W-1:0] oyw;
    logic signed [W-1:0] ea [3];
    logic signed [W-1:0] eb [3];
    logic signed [W-1:0] w0 [3];
    logic [2:0]          edge_split;
    logic [2:0]          edge_neg;
    logic signed [W-1:0] span_w;

    assign oxw    = W'(ox_reg);
    assign oyw    = W'(oy_reg);
    assign span_w = W'(SPAN);

    for (genvar e = 0; e < 3; e++)
    begin : g_edge
        localparam int P = (e + 1) % 3;
        localparam int Q = (e + 2) % 3;
        logic signed [W-1:0] ec;
        logic signed [W-1:0] s0;
        logic signed [W-1:0] s1;

        assign vxw[e] = W'(vx_reg[e]);
        assign vyw[e] = W'(vy_reg[e]);
        assign ea[e]  = vyw[P] - vyw[Q];
        assign eb[e]  = vxw[Q] - vxw[P];
        assign ec     = vxw[P] * vyw[Q] - vyw[P] * vxw[Q];
        assign w0[e]  = ea[e] * oxw + eb[e] * oyw + ec;

        // Sample the two corners where this edge function is extreme
        always_comb
        begin
            if (ea[e][W-1] != eb[e][W-1])
            begin
                s0 = w0[e] + ea[e] * span_w;
                s1 = w0[e] + eb[e] * span_w;
            end
            else
            begin
                s0 = w0[e] + (ea[e] + eb[e]) * span_w;
                s1 = w0[e];
            end
        end

        assign edge_split[e] = s0[W-1] != s1[W-1];
        assign edge_neg[e]   = w0[e][W-1];
    end

    // Doubled area as the cross product of the edges from vertex 0 to vertices 1 and 2
    logic signed [W-1:0] area_w;
    assign area_w = (vxw[1] - vxw[0]) * (vyw[2] - vyw[0])
                  - (vxw[2] - vxw[0]) * (vyw[1] - vyw[0]);

    // ------------------------------------------------------------------
    // Per-pixel tests, only for pixels that land in the mask port
    // ------------------------------------------------------------------
    logic [MW-1:0] full_mask;
    logic [MW-1:0] pixel_mask;

    for (genvar i = 0; i < MW; i++)
    begin : g_pix
        if (i < NPIX)
        begin : g_on
            localparam int PX = i % TILE_DIM;
            localparam int PY = i / TILE_DIM;
            logic [2:0] pix_neg;
            for (genvar e = 0; e < 3; e++)
            begin : g_pe
                logic signed [W-1:0] wv;
                assign wv         = w0[e] + ea[e] * W'(PX) + eb[e] * W'(PY);
                assign pix_neg[e] = wv[W-1];
            end
            assign full_mask[i]  = 1'b1;
            assign pixel_mask[i] = pix_neg == 3'b000;
        end
        else
        begin : g_off
            assign full_mask[i]  = 1'b0;
            assign pixel_mask[i] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Classification and result register
    // ------------------------------------------------------------------
    ttc_pkg::tile_class_t class_next;
    logic [MW-1:0]        mask_next;

    always_comb
    begin
        priority if (edge_split == 3'b000 && edge_neg != 3'b000)
        begin
            class_next = ttc_pkg::TILE_OUTSIDE;
            mask_next  = '0;
        end
        else if (edge_split == 3'b000)
        begin
            class_next = ttc_pkg::TILE_INSIDE;
            mask_next  = full_mask;
        end
        else
        begin
            class_next = ttc_pkg::TILE_CROSSED;
            mask_next  = pixel_mask;
        end
    end

    ttc_pkg::tile_class_t               class_reg;
    logic [MW-1:0]                      mask_reg;
    logic signed [ttc_pkg::AREA_W-1:0]  area_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            class_reg <= class_next;
            mask_reg  <= mask_next;
            area_reg  <= area_w[ttc_pkg::AREA_W-1:0];
        end
    end

    assign tile_class    = class_reg;
    assign coverage_mask = mask_reg;
    assign doubled_area  = area_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_outside_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tile_class == ttc_pkg::TILE_OUTSIDE |-> coverage_mask == '0)
        else $error("outside tile carries coverage");

    a_inside_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tile_class == ttc_pkg::TILE_INSIDE |-> coverage_mask == full_mask)
        else $error("inside tile mask not full");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both stages full");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance |=> out_valid_reg)
        else $error("item lost between stages");

endmodule
